[src/packet_five_tuple_filter_core_macros.svh]
// assertion macros for the five-tuple filter core
// no dependencies; included by the files that assert
`ifndef PACKET_FIVE_TUPLE_FILTER_CORE_MACROS_SVH
`define PACKET_FIVE_TUPLE_FILTER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define PFTF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define PFTF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/pftf_pkg.sv]
// shared types and constants of the five-tuple filter core
// no dependencies
package pftf_pkg;

  localparam int RULE_SLOTS = 32;
  localparam int RULE_IDX_W = $clog2(RULE_SLOTS);

  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_RULE  = 1'b1;

  localparam logic [1:0] ACT_DROP     = 2'd0;
  localparam logic [1:0] ACT_ALLOW    = 2'd1;
  localparam logic [1:0] ACT_REDIRECT = 2'd2;
  localparam logic [1:0] ACT_COUNT    = 2'd3;

  localparam logic [2:0] RSN_NON_IP    = 3'd0;
  localparam logic [2:0] RSN_MALFORMED = 3'd1;
  localparam logic [2:0] RSN_DROP      = 3'd2;
  localparam logic [2:0] RSN_ALLOW     = 3'd3;
  localparam logic [2:0] RSN_REDIRECT  = 3'd4;
  localparam logic [2:0] RSN_DEFAULT   = 3'd5;

  localparam logic [15:0] ETH_IPV4  = 16'h0800;
  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [7:0]  PROTO_UDP = 8'd17;
  localparam logic [6:0]  POS_MAX   = 7'd127;

  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [1:0]  action;
    logic [7:0]  protocol;
    logic [15:0] src_l4;
    logic [15:0] dst_l4;
  } rule_t;

  typedef struct packed {
    logic                  wr_en;
    logic [RULE_IDX_W-1:0] wr_idx;
    logic                  wr_valid;
  } rule_wr_t;

endpackage

[src/pftf_rule_mem.sv]
// rule table: synchronous memory with registered read
// plus per-slot valid flags cleared at reset; depends on pftf_pkg
module pftf_rule_mem import pftf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rule_wr_t              wr_ctl,
  input  rule_t                 wr_entry,
  input  logic [RULE_IDX_W-1:0] rd_idx,
  output rule_t                 rd_entry,
  output logic                  rd_valid
);

  rule_t                 mem [RULE_SLOTS];
  logic [RULE_SLOTS-1:0] valid_r;
  rule_t                 rd_entry_r;
  logic                  rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_ctl.wr_en) begin
      mem[wr_ctl.wr_idx] <= wr_entry;
    end
    rd_entry_r <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_ctl.wr_en) begin
        valid_r[wr_ctl.wr_idx] <= wr_ctl.wr_valid;
      end
      rd_valid_r <= valid_r[rd_idx];
    end
  end

  assign rd_entry = rd_entry_r;
  assign rd_valid = rd_valid_r;

endmodule

[src/packet_five_tuple_filter_core.sv]
// five-tuple filter core: byte parser, rule walk over the rule memory, counters
// depends on pftf_pkg, pftf_rule_mem and the assertion macro header
// a non-IP or malformed result appears in the cycle after the last byte; otherwise
// the result follows a rule walk that reads one slot per cycle
// throughput: one byte or rule write per cycle; input stalls during the walk
// and while a result waits; reset clears frame state, counters and rule valids
`include "packet_five_tuple_filter_core_macros.svh"

module packet_five_tuple_filter_core import pftf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_operation,
  input  logic [7:0]            in_pkt_byte,
  input  logic                  in_pkt_last,
  input  logic [RULE_IDX_W-1:0] in_rule_index,
  input  logic                  in_rule_valid,
  input  logic [31:0]           in_rule_src_ip,
  input  logic [31:0]           in_rule_dst_ip,
  input  logic [15:0]           in_rule_src_port,
  input  logic [15:0]           in_rule_dst_port,
  input  logic [7:0]            in_rule_protocol,
  input  logic [1:0]            in_rule_action,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_verdict_drop,
  output logic [2:0]            out_decision_reason,
  output logic                  out_rule_hit,
  output logic [RULE_IDX_W-1:0] out_hit_index,
  output logic [63:0]           out_total_count,
  output logic [63:0]           out_allowed_count,
  output logic [63:0]           out_dropped_count,
  output logic [63:0]           out_redirected_count
);

  typedef enum logic {ST_IDLE, ST_WALK} state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   drop_r, hit_r;
  logic [2:0] reason_r;
  logic [RULE_IDX_W-1:0] hidx_r, slot_r, rd_idx;
  logic [63:0] total_r, allowed_r, dropped_r, redir_r;

  logic [6:0]  pos_r, pos_nxt;
  logic [15:0] eth_r, eth_nxt;
  logic [7:0]  vihl_r, vihl_nxt, proto_r, proto_nxt;
  logic [31:0] src_r, src_nxt, dst_r, dst_nxt, ports_r, ports_nxt;
  logic [31:0] key_src_r, key_dst_r;
  logic [7:0]  key_proto_r;
  logic [15:0] key_sport_r, key_dport_r;

  logic accept, is_byte, is_last;
  logic [7:0] tofs, tofs_n, len8;
  logic [3:0] ihl_n;
  logic non_ip, bad_ip, trunc, l4;

  rule_wr_t wr_ctl;
  rule_t    wr_entry, rd_entry;
  logic     rd_valid, match, decide, walk_end;
  logic [1:0] inc_total;
  logic inc_allow, inc_drop, inc_redir;

  assign in_stall = (state_r != ST_IDLE) || out_valid_r;
  assign accept   = in_valid && !in_stall;
  assign is_byte  = accept && (in_operation == OP_BYTE);
  assign is_last  = is_byte && in_pkt_last;

  // byte parser
  always_comb begin
    tofs      = 8'd14 + {2'b00, vihl_r[3:0], 2'b00};
    eth_nxt   = eth_r;
    vihl_nxt  = vihl_r;
    proto_nxt = proto_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    ports_nxt = ports_r;
    case (pos_r)
      7'd12: eth_nxt = {in_pkt_byte, eth_r[7:0]};
      7'd13: eth_nxt = {eth_r[15:8], in_pkt_byte};
      7'd14: vihl_nxt = in_pkt_byte;
      7'd23: proto_nxt = in_pkt_byte;
      default: begin
        if (pos_r inside {[7'd26:7'd29]}) src_nxt = {src_r[23:0], in_pkt_byte};
        else if (pos_r inside {[7'd30:7'd33]}) dst_nxt = {dst_r[23:0], in_pkt_byte};
      end
    endcase
    if (pos_r >= 7'd34 && {1'b0, pos_r} >= tofs && {1'b0, pos_r} < tofs + 8'd4 &&
        pos_r < POS_MAX) begin
      ports_nxt = {ports_r[23:0], in_pkt_byte};
    end
    pos_nxt = (pos_r == POS_MAX) ? POS_MAX : pos_r + 7'd1;
  end

  // frame checks on the values after the last byte
  always_comb begin
    len8   = {1'b0, pos_nxt};
    ihl_n  = vihl_nxt[3:0];
    tofs_n = 8'd14 + {2'b00, ihl_n, 2'b00};
    non_ip = (pos_nxt < 7'd14) || (eth_nxt != ETH_IPV4);
    bad_ip = (pos_nxt < 7'd34) || (vihl_nxt[7:4] != 4'd4) || (ihl_n < 4'd5);
    trunc  = ((proto_nxt == PROTO_TCP) && (len8 < tofs_n + 8'd20)) ||
             ((proto_nxt == PROTO_UDP) && (len8 < tofs_n + 8'd8));
    l4     = (proto_nxt == PROTO_TCP) || (proto_nxt == PROTO_UDP);
  end

  assign wr_ctl.wr_en    = accept && (in_operation == OP_RULE);
  assign wr_ctl.wr_idx   = in_rule_index;
  assign wr_ctl.wr_valid = in_rule_valid;
  assign wr_entry = '{src_ip: in_rule_src_ip, dst_ip: in_rule_dst_ip,
                      action: in_rule_action, protocol: in_rule_protocol,
                      src_l4: in_rule_src_port, dst_l4: in_rule_dst_port};
  assign rd_idx = (state_r == ST_IDLE) ? '0 : slot_r + RULE_IDX_W'(1);

  pftf_rule_mem u_rule_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_ctl   (wr_ctl),
    .wr_entry (wr_entry),
    .rd_idx   (rd_idx),
    .rd_entry (rd_entry),
    .rd_valid (rd_valid)
  );

  // rule compare for the slot whose data is on the read port
  always_comb begin
    match = rd_valid &&
            (rd_entry.src_ip == '0 || rd_entry.src_ip == key_src_r) &&
            (rd_entry.dst_ip == '0 || rd_entry.dst_ip == key_dst_r) &&
            (rd_entry.protocol == '0 || rd_entry.protocol == key_proto_r) &&
            (rd_entry.src_l4 == '0 || rd_entry.src_l4 == key_sport_r) &&
            (rd_entry.dst_l4 == '0 || rd_entry.dst_l4 == key_dport_r);
    decide   = (state_r == ST_WALK) && match && (rd_entry.action != ACT_COUNT);
    walk_end = (state_r == ST_WALK) && !decide && (slot_r == RULE_IDX_W'(RULE_SLOTS - 1));
    inc_total = 2'd0;
    inc_allow = 1'b0;
    inc_drop  = 1'b0;
    inc_redir = 1'b0;
    if (is_last && non_ip) begin
      inc_total = 2'd1;
      inc_allow = 1'b1;
    end else if (is_last && (bad_ip || trunc)) begin
      inc_total = 2'd1;
      inc_drop  = 1'b1;
    end
    if (state_r == ST_WALK && match) begin
      inc_total = 2'd1;
      inc_drop  = (rd_entry.action == ACT_DROP);
      inc_allow = (rd_entry.action == ACT_ALLOW);
      inc_redir = (rd_entry.action == ACT_REDIRECT);
    end
    if (walk_end) begin
      inc_total = inc_total + 2'd1;
      inc_redir = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      slot_r      <= '0;
      pos_r       <= '0;
      eth_r       <= '0;
      vihl_r      <= '0;
      proto_r     <= '0;
      src_r       <= '0;
      dst_r       <= '0;
      ports_r     <= '0;
      total_r     <= '0;
      allowed_r   <= '0;
      dropped_r   <= '0;
      redir_r     <= '0;
    end else begin
      total_r   <= total_r + 64'(inc_total);
      allowed_r <= allowed_r + 64'(inc_allow);
      dropped_r <= dropped_r + 64'(inc_drop);
      redir_r   <= redir_r + 64'(inc_redir);
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (is_last) begin
        pos_r   <= '0;
        eth_r   <= '0;
        vihl_r  <= '0;
        proto_r <= '0;
        src_r   <= '0;
        dst_r   <= '0;
        ports_r <= '0;
        key_src_r   <= src_nxt;
        key_dst_r   <= dst_nxt;
        key_proto_r <= proto_nxt;
        key_sport_r <= l4 ? ports_nxt[31:16] : 16'd0;
        key_dport_r <= l4 ? ports_nxt[15:0] : 16'd0;
        hit_r  <= 1'b0;
        hidx_r <= '0;
        if (non_ip) begin
          out_valid_r <= 1'b1;
          drop_r      <= 1'b0;
          reason_r    <= RSN_NON_IP;
        end else if (bad_ip || trunc) begin
          out_valid_r <= 1'b1;
          drop_r      <= 1'b1;
          reason_r    <= RSN_MALFORMED;
        end else begin
          state_r <= ST_WALK;
          slot_r  <= '0;
        end
      end else if (is_byte) begin
        pos_r   <= pos_nxt;
        eth_r   <= eth_nxt;
        vihl_r  <= vihl_nxt;
        proto_r <= proto_nxt;
        src_r   <= src_nxt;
        dst_r   <= dst_nxt;
        ports_r <= ports_nxt;
      end
      case (state_r)
        ST_WALK: begin
          slot_r <= slot_r + RULE_IDX_W'(1);
          if (decide) begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b1;
            hit_r       <= 1'b1;
            hidx_r      <= slot_r;
            drop_r      <= (rd_entry.action == ACT_DROP);
            reason_r    <= RSN_DROP + {1'b0, rd_entry.action};
          end else if (walk_end) begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b1;
            drop_r      <= 1'b0;
            reason_r    <= RSN_DEFAULT;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_verdict_drop     = drop_r;
  assign out_decision_reason  = reason_r;
  assign out_rule_hit         = hit_r;
  assign out_hit_index        = hidx_r;
  assign out_total_count      = total_r;
  assign out_allowed_count    = allowed_r;
  assign out_dropped_count    = dropped_r;
  assign out_redirected_count = redir_r;

  `PFTF_ASSERT_NOW(a_hit_reason, clk, rst_n, out_valid_r && hit_r,
    reason_r == RSN_DROP || reason_r == RSN_ALLOW || reason_r == RSN_REDIRECT,
    "rule hit with non-rule reason")
  `PFTF_ASSERT_NOW(a_nohit_index, clk, rst_n, out_valid_r && !hit_r, hidx_r == '0,
    "hit index set without a hit")
  `PFTF_ASSERT_NOW(a_drop_reason, clk, rst_n, out_valid_r,
    drop_r == (reason_r == RSN_DROP || reason_r == RSN_MALFORMED),
    "verdict disagrees with reason")
  `PFTF_ASSERT_NEXT(a_walk_done, clk, rst_n, decide || walk_end,
    state_r == ST_IDLE && out_valid_r, "walk ended without a result")

endmodule
